@@ rtl/core/rmse_pkg.sv @@
// ----------------------------------------------------------------------------
// rmse_pkg
// Shared widths, limits, state codes and unit control types for the running
// mean and standard error unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmse_pkg;

   localparam int unsigned MAX_SAMPLES = 65536;

   localparam int unsigned SAMPLE_W   = 24;
   localparam int unsigned ERROR_W    = 23;
   localparam int unsigned COUNT_W    = 17;
   localparam int unsigned TOTAL_W    = 40;
   localparam int unsigned SQUARE_W   = 64;
   localparam int unsigned PROD_W     = 48;
   localparam int unsigned DIVISOR_W  = 18;
   localparam int unsigned QUOT_W     = 48;
   localparam int unsigned STEP_W     = 6;
   localparam int unsigned ROOT_W     = 24;
   localparam int unsigned RADICAND_W = 48;
   localparam int unsigned SQ_CNT_W   = 5;

   localparam logic [COUNT_W-1:0]  MAX_COUNT    = COUNT_W'(MAX_SAMPLES);
   localparam logic [STEP_W-1:0]   MEAN_STEPS   = 6'd24;
   localparam logic [STEP_W-1:0]   MOMENT_STEPS = 6'd47;
   localparam logic [SQ_CNT_W-1:0] SQ_STEPS     = 5'd24;
   localparam logic [SQ_CNT_W-1:0] ROOT_STEPS   = 5'd24;
   localparam logic [ERROR_W-1:0]  ERROR_MAX    = {ERROR_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_MEAN_GO,
      ST_MEAN,
      ST_MEAN_SQ,
      ST_MOMENT,
      ST_VAR_GO,
      ST_VAR,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [STEP_W-1:0]     steps;
      logic [SQUARE_W-1:0]   dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [QUOT_W-1:0]     quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [RADICAND_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic                  done;
      logic [ROOT_W-1:0]     root;
   } sqrt_rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/rmse_if.sv @@
// ----------------------------------------------------------------------------
// rmse channel interfaces
// Valid/ready channels for samples in and statistics out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmse_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rmse_pkg::SAMPLE_W-1:0] sample;
   logic                                restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmse_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rmse_pkg::SAMPLE_W-1:0] running_mean;
   logic [rmse_pkg::ERROR_W-1:0]         standard_error;
   logic [rmse_pkg::COUNT_W-1:0]         sample_number;
   logic                                refused;

   modport source (output valid, output running_mean, output standard_error,
                   output sample_number, output refused, input ready);
   modport sink   (input valid, input running_mean, input standard_error,
                   input sample_number, input refused, output ready);
endinterface

`default_nettype wire

@@ rtl/core/running_mean_standard_error_unit.sv @@
// ----------------------------------------------------------------------------
// running_mean_standard_error_unit
// Running count, sum and sum of squares of Q8.16 samples, with the cumulative
// mean and the standard error of the mean after every sample.
//
//   channel   role     payload
//   req_bus   sink     sample (s24 Q8.16), restart
//   rsp_bus   source   running_mean (s24), standard_error (u23),
//                      sample_number (u17), refused
//
// Each sample passes the bit-serial squarer, divider (24 or 47 steps) and
// square root; the first of a series stops after the mean division.
// One sample is in work at a time; req_bus is ready only between samples.
// A result waits in the output register while the next sample is taken.
// Synchronous reset clears the count and both sums.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_standard_error_unit #(
   parameter int unsigned MAX_SAMPLES = rmse_pkg::MAX_SAMPLES
) (
   input wire logic  clock,
   input wire logic  reset,
   rmse_req_if.sink  req_bus,
   rmse_rsp_if.source rsp_bus
);

   localparam logic [rmse_pkg::COUNT_W-1:0] COUNT_LIMIT = MAX_SAMPLES[rmse_pkg::COUNT_W-1:0];

   rmse_pkg::state_type state_ff, state_in;

   logic [rmse_pkg::SAMPLE_W-1:0] sample_ff;
   logic                          refused_ff, refused_in;
   logic [rmse_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rmse_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [rmse_pkg::SQUARE_W-1:0] square_ff, square_in;

   logic [rmse_pkg::SAMPLE_W-1:0] sq_mcand_ff, sq_mcand_in;
   logic [rmse_pkg::SAMPLE_W-1:0] sq_hi_ff, sq_hi_in;
   logic [rmse_pkg::SAMPLE_W-1:0] sq_lo_ff, sq_lo_in;
   logic [rmse_pkg::SQ_CNT_W-1:0] sq_cnt_ff, sq_cnt_in;

   logic [rmse_pkg::SAMPLE_W-1:0]   mean_ff, mean_in;
   logic [rmse_pkg::ERROR_W-1:0]    err_ff, err_in;
   logic [rmse_pkg::RADICAND_W-1:0] var_num_ff, var_num_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rmse_pkg::SAMPLE_W-1:0] rsp_mean_ff;
   logic [rmse_pkg::ERROR_W-1:0]  rsp_error_ff;
   logic [rmse_pkg::COUNT_W-1:0]  rsp_number_ff;
   logic                          rsp_refused_ff;

   rmse_pkg::div_req_type  div_req;
   rmse_pkg::div_rsp_type  div_rsp;
   rmse_pkg::sqrt_req_type sqrt_req;
   rmse_pkg::sqrt_rsp_type sqrt_rsp;

   // control pulses
   logic accept;
   logic accept_refused;
   logic sq_load_sample;
   logic sq_load_mean;
   logic accum_en;
   logic mean_go;
   logic moment_go;
   logic var_go;
   logic mean_capture;
   logic var_capture;
   logic root_go;
   logic err_capture;
   logic err_clear;
   logic result_load;

   // datapath helpers
   logic [rmse_pkg::SAMPLE_W-1:0] sample_mag;
   logic [rmse_pkg::SAMPLE_W:0]   sq_sum;
   logic [rmse_pkg::PROD_W-1:0]   sq_prod;
   logic [rmse_pkg::TOTAL_W:0]    total_x2;
   logic [rmse_pkg::TOTAL_W:0]    count_ext;
   logic [rmse_pkg::TOTAL_W:0]    mean_numer;
   logic [rmse_pkg::SAMPLE_W-1:0] mean_mag;
   logic [rmse_pkg::PROD_W:0]     moment_diff;
   logic                          series_short;
   logic                          out_free;

   rmse_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rmse_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   always_comb begin
      sample_mag   = req_bus.sample[rmse_pkg::SAMPLE_W-1] ?
                     (~req_bus.sample + 24'd1) : req_bus.sample;
      sq_sum       = {1'b0, sq_hi_ff} + (sq_lo_ff[0] ? {1'b0, sq_mcand_ff} : 25'd0);
      sq_prod      = {sq_hi_ff, sq_lo_ff};
      total_x2     = {total_ff, 1'b0};
      count_ext    = {24'd0, count_ff};
      mean_numer   = total_ff[rmse_pkg::TOTAL_W-1] ? (count_ext - total_x2)
                                                   : (count_ext + total_x2);
      mean_mag     = div_rsp.quotient[rmse_pkg::SAMPLE_W-1:0];
      moment_diff  = {1'b0, div_rsp.quotient} - {1'b0, sq_prod};
      series_short = (count_ff[rmse_pkg::COUNT_W-1:1] == '0);
      out_free     = ~rsp_valid_ff | rsp_bus.ready;
      accept       = req_bus.valid & (state_ff == rmse_pkg::ST_IDLE);
      accept_refused = ~req_bus.restart & (count_ff >= COUNT_LIMIT);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmse_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = accept_refused ? rmse_pkg::ST_MEAN_GO : rmse_pkg::ST_SQUARE;
            end
         end
         rmse_pkg::ST_SQUARE: begin
            if (sq_cnt_ff == '0) begin
               state_in = rmse_pkg::ST_ACCUM;
            end
         end
         rmse_pkg::ST_ACCUM:   state_in = rmse_pkg::ST_MEAN_GO;
         rmse_pkg::ST_MEAN_GO: state_in = rmse_pkg::ST_MEAN;
         rmse_pkg::ST_MEAN: begin
            if (div_rsp.done) begin
               state_in = series_short ? rmse_pkg::ST_FINISH : rmse_pkg::ST_MEAN_SQ;
            end
         end
         rmse_pkg::ST_MEAN_SQ: begin
            if (sq_cnt_ff == '0) begin
               state_in = rmse_pkg::ST_MOMENT;
            end
         end
         rmse_pkg::ST_MOMENT: begin
            if (div_rsp.done) begin
               state_in = rmse_pkg::ST_VAR_GO;
            end
         end
         rmse_pkg::ST_VAR_GO: state_in = rmse_pkg::ST_VAR;
         rmse_pkg::ST_VAR: begin
            if (div_rsp.done) begin
               state_in = rmse_pkg::ST_ROOT;
            end
         end
         rmse_pkg::ST_ROOT: begin
            if (sqrt_rsp.done) begin
               state_in = rmse_pkg::ST_FINISH;
            end
         end
         rmse_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = rmse_pkg::ST_IDLE;
            end
         end
         default: state_in = rmse_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      sq_load_sample = 1'b0;
      sq_load_mean   = 1'b0;
      accum_en       = 1'b0;
      mean_go        = 1'b0;
      moment_go      = 1'b0;
      var_go         = 1'b0;
      mean_capture   = 1'b0;
      var_capture    = 1'b0;
      root_go        = 1'b0;
      err_capture    = 1'b0;
      err_clear      = 1'b0;
      result_load    = 1'b0;
      case (state_ff)
         rmse_pkg::ST_IDLE:    sq_load_sample = accept & ~accept_refused;
         rmse_pkg::ST_SQUARE:  ;
         rmse_pkg::ST_ACCUM:   accum_en = 1'b1;
         rmse_pkg::ST_MEAN_GO: mean_go = 1'b1;
         rmse_pkg::ST_MEAN: begin
            mean_capture = div_rsp.done;
            sq_load_mean = div_rsp.done & ~series_short;
            err_clear    = div_rsp.done & series_short;
         end
         rmse_pkg::ST_MEAN_SQ: moment_go   = (sq_cnt_ff == '0);
         rmse_pkg::ST_MOMENT:  var_capture = div_rsp.done;
         rmse_pkg::ST_VAR_GO:  var_go      = 1'b1;
         rmse_pkg::ST_VAR:     root_go     = div_rsp.done;
         rmse_pkg::ST_ROOT:    err_capture = sqrt_rsp.done;
         rmse_pkg::ST_FINISH:  result_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      div_req.start    = mean_go | moment_go | var_go;
      div_req.steps    = rmse_pkg::MOMENT_STEPS;
      div_req.dividend = square_ff;
      div_req.divisor  = {1'b0, count_ff};
      if (mean_go) begin
         div_req.steps    = rmse_pkg::MEAN_STEPS;
         div_req.dividend = {23'd0, mean_numer};
         div_req.divisor  = {count_ff, 1'b0};
      end else if (var_go) begin
         div_req.dividend = {16'd0, var_num_ff};
         div_req.divisor  = {1'b0, count_ff - 17'd1};
      end
      sqrt_req.start    = root_go;
      sqrt_req.radicand = div_rsp.quotient;
   end

   always_comb begin
      refused_in  = refused_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      square_in   = square_ff;
      sq_mcand_in = sq_mcand_ff;
      sq_hi_in    = sq_hi_ff;
      sq_lo_in    = sq_lo_ff;
      sq_cnt_in   = sq_cnt_ff;
      mean_in     = mean_ff;
      err_in      = err_ff;
      var_num_in  = var_num_ff;
      if (accept) begin
         refused_in = accept_refused;
         if (req_bus.restart) begin
            count_in  = '0;
            total_in  = '0;
            square_in = '0;
         end
      end
      if (accum_en) begin
         count_in  = count_ff + 17'd1;
         total_in  = total_ff + {{16{sample_ff[rmse_pkg::SAMPLE_W-1]}}, sample_ff};
         square_in = square_ff + {16'd0, sq_prod};
      end
      if (sq_load_sample || sq_load_mean) begin
         sq_mcand_in = sq_load_mean ? mean_mag : sample_mag;
         sq_lo_in    = sq_load_mean ? mean_mag : sample_mag;
         sq_hi_in    = '0;
         sq_cnt_in   = rmse_pkg::SQ_STEPS;
      end else if (sq_cnt_ff != '0) begin
         sq_hi_in  = sq_sum[rmse_pkg::SAMPLE_W:1];
         sq_lo_in  = {sq_sum[0], sq_lo_ff[rmse_pkg::SAMPLE_W-1:1]};
         sq_cnt_in = sq_cnt_ff - 5'd1;
      end
      if (mean_capture) begin
         mean_in = total_ff[rmse_pkg::TOTAL_W-1] ? (~mean_mag + 24'd1) : mean_mag;
      end
      if (var_capture) begin
         var_num_in = moment_diff[rmse_pkg::PROD_W] ? '0 : moment_diff[rmse_pkg::PROD_W-1:0];
      end
      if (err_clear) begin
         err_in = '0;
      end else if (err_capture) begin
         err_in = sqrt_rsp.root[rmse_pkg::ROOT_W-1] ? rmse_pkg::ERROR_MAX
                                                    : sqrt_rsp.root[rmse_pkg::ERROR_W-1:0];
      end
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmse_pkg::ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         square_ff    <= '0;
         sq_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         square_ff    <= square_in;
         sq_cnt_ff    <= sq_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         sample_ff <= req_bus.sample;
      end
      refused_ff  <= refused_in;
      sq_mcand_ff <= sq_mcand_in;
      sq_hi_ff    <= sq_hi_in;
      sq_lo_ff    <= sq_lo_in;
      mean_ff     <= mean_in;
      err_ff      <= err_in;
      var_num_ff  <= var_num_in;
      if (result_load) begin
         rsp_mean_ff    <= mean_ff;
         rsp_error_ff   <= err_ff;
         rsp_number_ff  <= count_ff;
         rsp_refused_ff <= refused_ff;
      end
   end

   assign req_bus.ready          = (state_ff == rmse_pkg::ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.running_mean   = rsp_mean_ff;
   assign rsp_bus.standard_error = rsp_error_ff;
   assign rsp_bus.sample_number  = rsp_number_ff;
   assign rsp_bus.refused        = rsp_refused_ff;

   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_refused_ff) |-> (rsp_number_ff == COUNT_LIMIT))
      else $error("refused result below full series");

   a_single_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_number_ff[rmse_pkg::COUNT_W-1:1] == '0)) |-> (rsp_error_ff == '0))
      else $error("nonzero error for single sample");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("sample count beyond limit");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == rmse_pkg::ST_MEAN || state_ff == rmse_pkg::ST_MOMENT ||
                        state_ff == rmse_pkg::ST_VAR))
      else $error("divider finished outside a wait state");

   a_hold_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmse_pkg::ST_FINISH && rsp_valid_ff && !rsp_bus.ready) |=>
      (state_ff == rmse_pkg::ST_FINISH))
      else $error("result overwrote a waiting transfer");

endmodule

`default_nettype wire

@@ rtl/core/rmse_div.sv @@
// ----------------------------------------------------------------------------
// rmse_div
// Bit-serial restoring divider, one quotient bit per cycle. The dividend is
// split at load so that only the requested number of quotient bits is made.
// ----------------------------------------------------------------------------
`default_nettype none

module rmse_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rmse_pkg::div_req_type req,
   output rmse_pkg::div_rsp_type      rsp
);

   logic [rmse_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [rmse_pkg::SQUARE_W-1:0]  num_ff, num_in;
   logic [rmse_pkg::DIVISOR_W-1:0] div_ff, div_in;
   logic [rmse_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [rmse_pkg::DIVISOR_W:0]   trial;
   logic [rmse_pkg::DIVISOR_W+1:0] diff;
   logic                           ge;
   logic [rmse_pkg::SQUARE_W-1:0]  low_part;
   logic [rmse_pkg::SQUARE_W-1:0]  high_part;

   always_comb begin
      trial     = {rem_ff, num_ff[rmse_pkg::SQUARE_W-1]};
      diff      = {1'b0, trial} - {2'b00, div_ff};
      ge        = ~diff[rmse_pkg::DIVISOR_W+1];
      high_part = req.dividend >> req.steps;
      low_part  = req.dividend << (7'd64 - {1'b0, req.steps});
   end

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = high_part[rmse_pkg::DIVISOR_W-1:0];
         num_in  = low_part;
         div_in  = req.divisor;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[rmse_pkg::DIVISOR_W-1:0] : trial[rmse_pkg::DIVISOR_W-1:0];
         num_in  = {num_ff[rmse_pkg::SQUARE_W-2:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff[rmse_pkg::QUOT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/rmse_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmse_sqrt
// Digit-by-digit integer square root, one root bit per cycle from the top
// pair of radicand bits down.
// ----------------------------------------------------------------------------
`default_nettype none

module rmse_sqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rmse_pkg::sqrt_req_type req,
   output rmse_pkg::sqrt_rsp_type      rsp
);

   logic [rmse_pkg::RADICAND_W-1:0] rad_ff, rad_in;
   logic [25:0]                     rem_ff, rem_in;
   logic [rmse_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [rmse_pkg::SQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [27:0] r2;
   logic [27:0] trial;
   logic [28:0] diff;
   logic        ge;

   always_comb begin
      r2    = {rem_ff, rad_ff[rmse_pkg::RADICAND_W-1 -: 2]};
      trial = {2'b00, root_ff, 2'b01};
      diff  = {1'b0, r2} - {1'b0, trial};
      ge    = ~diff[28];
   end

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rad_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = rmse_pkg::ROOT_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[rmse_pkg::RADICAND_W-3:0], 2'b00};
         rem_in  = ge ? diff[25:0] : r2[25:0];
         root_in = {root_ff[rmse_pkg::ROOT_W-2:0], ge};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

`default_nettype wire
